/* design/calendar_day_count_converter_unit_assert.svh */
// Assertion macros for the calendar day count converter.
`ifndef CALENDAR_DAY_COUNT_CONVERTER_UNIT_ASSERT_SVH
`define CALENDAR_DAY_COUNT_CONVERTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define CDCC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CDCC_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CDCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CDCC_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

/* design/cdcc_pkg.sv */
// Constants, stage types and month table for the calendar day count converter.
package cdcc_pkg;

    localparam int NUM_STAGES = 12;

    localparam logic [21:0] MAX_COUNT     = 22'd2932896;
    localparam logic [21:0] EPOCH_SHIFT   = 22'd719468;
    localparam logic [21:0] WEEK_OFFSET   = 22'd4;
    localparam logic [21:0] DAYS_PER_WEEK = 22'd7;
    localparam logic [17:0] ERA_DAYS      = 18'd146097;
    localparam logic [17:0] ERA_LAST_DAY  = 18'd146096;
    localparam logic [17:0] CENTURY_DAYS  = 18'd36524;
    localparam logic [8:0]  YEAR_DAYS     = 9'd365;
    localparam logic [8:0]  ERA_YEARS     = 9'd400;
    localparam logic [13:0] YEAR_MIN      = 14'd1970;
    localparam logic [13:0] YEAR_MAX      = 14'd9999;
    localparam logic [3:0]  MONTH_FEB     = 4'd2;
    localparam logic [3:0]  MONTH_DEC     = 4'd12;
    localparam logic [3:0]  MP_JAN        = 4'd10;

    // Reciprocals: q = (x * RCP) >> SHIFT, exact over the value range used
    localparam logic [12:0] RCP_25    = 13'd5243;     // shift 17
    localparam logic [21:0] RCP_ERA   = 22'd3762951;  // shift 39
    localparam logic [22:0] RCP_7     = 23'd4793491;  // shift 25
    localparam logic [17:0] RCP_1460  = 18'd183860;   // shift 28
    localparam logic [17:0] RCP_365   = 18'd183860;   // shift 26
    localparam logic [7:0]  RCP_100   = 8'd164;       // shift 14
    localparam logic [12:0] RCP_153   = 13'd6854;     // shift 20

    typedef struct packed {
        logic        err;
        logic        kind;
        logic [21:0] cnt;
        logic [13:0] yy;
        logic [8:0]  doy;
        logic [21:0] p365;
    } st1_t;

    typedef struct packed {
        logic        err;
        logic        kind;
        logic [21:0] cnt;
        logic [21:0] base;
        logic [6:0]  q100;
        logic [4:0]  q400;
    } st2_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
    } st3_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [21:0] z;
        logic [4:0]  era;
    } st4_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [18:0] q7;
    } st5_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [2:0]  wd;
        logic [17:0] acc;
        logic [6:0]  q1460;
    } st6_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [2:0]  wd;
        logic [17:0] tdays;
    } st7_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [2:0]  wd;
        logic [8:0]  yoe;
    } st8_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [17:0] doe;
        logic [2:0]  wd;
        logic [8:0]  yoe;
        logic [17:0] p365y;
        logic [1:0]  q100y;
    } st9_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [2:0]  wd;
        logic [8:0]  yoe;
        logic [8:0]  doy;
    } st10_t;

    typedef struct packed {
        logic        err;
        logic [21:0] count;
        logic [4:0]  era;
        logic [2:0]  wd;
        logic [8:0]  yoe;
        logic [8:0]  doy;
        logic [3:0]  mp;
    } st11_t;

    typedef struct packed {
        logic [21:0] day_count;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [13:0] year;
        logic [2:0]  weekday;
        logic        range_error;
    } out_t;

    // First day of a March-based month within its year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

/* design/calendar_day_count_converter_unit.sv */
// Gregorian date <-> day count converter (days since 1970-01-01), pipelined.
//
// Input channel s_*: s_kind selects the conversion. Kind 0 takes s_in_day, s_in_month
// and s_in_year and yields the day count; kind 1 takes s_in_day_count and yields the
// date. Every result beat on m_* carries count, date and weekday (0 = Sunday).
// Out-of-range inputs return m_range_error = 1 with all other fields zero.
//
// One beat is accepted per cycle unless the pipeline is full and stalled by m_ready.
// The depth is set by the chain of constant divisions (by 400-year era, 1460,
// 365, 100, 153 and 7), each done as a reciprocal multiply in its own stage.
//
// Each stage has its own valid bit and advances when it is empty or the next
// stage advances, so bubbles close up while m_ready is low and s_ready drops
// only when every stage holds a beat. Nothing is dropped or repeated on a stall.
// Synchronous active-low reset empties the pipeline; payload is not reset.
`include "calendar_day_count_converter_unit_assert.svh"

module calendar_day_count_converter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [4:0]  s_in_day,
    input  logic [3:0]  s_in_month,
    input  logic [13:0] s_in_year,
    input  logic [21:0] s_in_day_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [21:0] m_out_day_count,
    output logic [4:0]  m_out_day,
    output logic [3:0]  m_out_month,
    output logic [13:0] m_out_year,
    output logic [2:0]  m_weekday,
    output logic        m_range_error
);

    localparam int NSTG = cdcc_pkg::NUM_STAGES;

    logic [NSTG-1:0] vld_reg, vld_next, stg_en;

    cdcc_pkg::st1_t  st1_reg,  st1_next;
    cdcc_pkg::st2_t  st2_reg,  st2_next;
    cdcc_pkg::st3_t  st3_reg,  st3_next;
    cdcc_pkg::st4_t  st4_reg,  st4_next;
    cdcc_pkg::st5_t  st5_reg,  st5_next;
    cdcc_pkg::st6_t  st6_reg,  st6_next;
    cdcc_pkg::st7_t  st7_reg,  st7_next;
    cdcc_pkg::st8_t  st8_reg,  st8_next;
    cdcc_pkg::st9_t  st9_reg,  st9_next;
    cdcc_pkg::st10_t st10_reg, st10_next;
    cdcc_pkg::st11_t st11_reg, st11_next;
    cdcc_pkg::out_t  out_reg,  out_next;

    // stage-local arithmetic
    logic        mon_low;
    logic [3:0]  mp_in;
    logic [13:0] yy_in;
    logic [22:0] p365_in;
    logic [24:0] p100_s2;
    logic [22:0] p400_s2;
    logic [21:0] cnt_s3;
    logic [21:0] z_s4;
    logic [43:0] pz_s4;
    logic [22:0] eraday_s5;
    logic [22:0] doe_s5;
    logic [21:0] c4_s5;
    logic [44:0] p7_s5;
    logic [21:0] c4_s6;
    logic [21:0] wd_s6;
    logic [2:0]  qc_s6;
    logic        qe_s6;
    logic [35:0] p1460_s6;
    logic [35:0] p365_s8;
    logic [17:0] p365_s9;
    logic [16:0] p100_s9;
    logic [17:0] doy_s10;
    logic [10:0] x_s11;
    logic [23:0] pm_s11;
    logic [8:0]  day_out;
    logic [3:0]  mon_out;

    // ---------------------------------------------------------------- handshake
    genvar gi;
    generate
        for (gi = 0; gi < NSTG - 1; gi++) begin : g_en
            assign stg_en[gi] = ~vld_reg[gi] | stg_en[gi+1];
        end
    endgenerate
    assign stg_en[NSTG-1] = ~vld_reg[NSTG-1] | m_ready;

    always_comb begin
        vld_next[0] = stg_en[0] ? s_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++) begin
            vld_next[i] = stg_en[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    assign s_ready = stg_en[0];
    assign m_valid = vld_reg[NSTG-1];

    // ---------------------------------------------------------------- datapath
    // Stage 1: range check, March-based year and day of year, 365 * year
    assign mon_low = (s_in_month <= cdcc_pkg::MONTH_FEB);
    assign mp_in   = mon_low ? (s_in_month + 4'd9) : (s_in_month - 4'd3);
    assign yy_in   = s_in_year - {13'd0, mon_low};
    assign p365_in = 23'(yy_in) * 23'(cdcc_pkg::YEAR_DAYS);

    always_comb begin
        st1_next.kind = s_kind;
        st1_next.cnt  = s_in_day_count;
        st1_next.yy   = yy_in;
        st1_next.doy  = cdcc_pkg::month_start(mp_in) + {4'd0, s_in_day} - 9'd1;
        st1_next.p365 = p365_in[21:0];
        if (s_kind) begin
            st1_next.err = (s_in_day_count > cdcc_pkg::MAX_COUNT);
        end else begin
            st1_next.err = (s_in_day == 5'd0) || (s_in_month == 4'd0) ||
                           (s_in_month > cdcc_pkg::MONTH_DEC) ||
                           (s_in_year < cdcc_pkg::YEAR_MIN) ||
                           (s_in_year > cdcc_pkg::YEAR_MAX);
        end
    end

    // Stage 2: leap corrections year/100 and year/400 as (year/4)/25, (year/16)/25
    assign p100_s2 = 25'(st1_reg.yy[13:2]) * 25'(cdcc_pkg::RCP_25);
    assign p400_s2 = 23'(st1_reg.yy[13:4]) * 23'(cdcc_pkg::RCP_25);

    always_comb begin
        st2_next.err  = st1_reg.err;
        st2_next.kind = st1_reg.kind;
        st2_next.cnt  = st1_reg.cnt;
        st2_next.base = st1_reg.p365 + {13'd0, st1_reg.doy} + {10'd0, st1_reg.yy[13:2]};
        st2_next.q100 = p100_s2[23:17];
        st2_next.q400 = p400_s2[21:17];
    end

    // Stage 3: day count, or the input count for kind 1; zero on error
    assign cnt_s3 = st2_reg.base - {15'd0, st2_reg.q100} + {17'd0, st2_reg.q400}
                    - cdcc_pkg::EPOCH_SHIFT;

    always_comb begin
        st3_next.err = st2_reg.err;
        if (st2_reg.err) begin
            st3_next.count = 22'd0;
        end else if (st2_reg.kind) begin
            st3_next.count = st2_reg.cnt;
        end else begin
            st3_next.count = cnt_s3;
        end
    end

    // Stage 4: shift epoch to 0000-03-01, era = z / 146097
    assign z_s4  = st3_reg.count + cdcc_pkg::EPOCH_SHIFT;
    assign pz_s4 = 44'(z_s4) * 44'(cdcc_pkg::RCP_ERA);

    always_comb begin
        st4_next.err   = st3_reg.err;
        st4_next.count = st3_reg.count;
        st4_next.z     = z_s4;
        st4_next.era   = pz_s4[43:39];
    end

    // Stage 5: day of era; weekday quotient (count + 4) / 7
    assign eraday_s5 = 23'(st4_reg.era) * 23'(cdcc_pkg::ERA_DAYS);
    assign doe_s5    = {1'b0, st4_reg.z} - eraday_s5;
    assign c4_s5     = st4_reg.count + cdcc_pkg::WEEK_OFFSET;
    assign p7_s5     = 45'(c4_s5) * 45'(cdcc_pkg::RCP_7);

    always_comb begin
        st5_next.err   = st4_reg.err;
        st5_next.count = st4_reg.count;
        st5_next.era   = st4_reg.era;
        st5_next.doe   = doe_s5[17:0];
        st5_next.q7    = p7_s5[43:25];
    end

    // Stage 6: weekday remainder; doe / 36524, doe / 146096, doe / 1460
    assign c4_s6    = st5_reg.count + cdcc_pkg::WEEK_OFFSET;
    assign wd_s6    = c4_s6 - 22'(st5_reg.q7) * cdcc_pkg::DAYS_PER_WEEK;
    assign qe_s6    = (st5_reg.doe == cdcc_pkg::ERA_LAST_DAY);
    assign p1460_s6 = 36'(st5_reg.doe) * 36'(cdcc_pkg::RCP_1460);

    always_comb begin
        if (st5_reg.doe >= 18'(4 * cdcc_pkg::CENTURY_DAYS)) begin
            qc_s6 = 3'd4;
        end else if (st5_reg.doe >= 18'(3 * cdcc_pkg::CENTURY_DAYS)) begin
            qc_s6 = 3'd3;
        end else if (st5_reg.doe >= 18'(2 * cdcc_pkg::CENTURY_DAYS)) begin
            qc_s6 = 3'd2;
        end else if (st5_reg.doe >= cdcc_pkg::CENTURY_DAYS) begin
            qc_s6 = 3'd1;
        end else begin
            qc_s6 = 3'd0;
        end
        st6_next.err   = st5_reg.err;
        st6_next.count = st5_reg.count;
        st6_next.era   = st5_reg.era;
        st6_next.doe   = st5_reg.doe;
        st6_next.wd    = wd_s6[2:0];
        st6_next.acc   = st5_reg.doe + {15'd0, qc_s6} - {17'd0, qe_s6};
        st6_next.q1460 = p1460_s6[34:28];
    end

    // Stage 7: leap-adjusted day of era
    always_comb begin
        st7_next.err   = st6_reg.err;
        st7_next.count = st6_reg.count;
        st7_next.era   = st6_reg.era;
        st7_next.doe   = st6_reg.doe;
        st7_next.wd    = st6_reg.wd;
        st7_next.tdays = st6_reg.acc - {11'd0, st6_reg.q1460};
    end

    // Stage 8: year of era = tdays / 365
    assign p365_s8 = 36'(st7_reg.tdays) * 36'(cdcc_pkg::RCP_365);

    always_comb begin
        st8_next.err   = st7_reg.err;
        st8_next.count = st7_reg.count;
        st8_next.era   = st7_reg.era;
        st8_next.doe   = st7_reg.doe;
        st8_next.wd    = st7_reg.wd;
        st8_next.yoe   = p365_s8[34:26];
    end

    // Stage 9: days before the year within the era
    assign p365_s9 = 18'(st8_reg.yoe) * 18'(cdcc_pkg::YEAR_DAYS);
    assign p100_s9 = 17'(st8_reg.yoe) * 17'(cdcc_pkg::RCP_100);

    always_comb begin
        st9_next.err   = st8_reg.err;
        st9_next.count = st8_reg.count;
        st9_next.era   = st8_reg.era;
        st9_next.doe   = st8_reg.doe;
        st9_next.wd    = st8_reg.wd;
        st9_next.yoe   = st8_reg.yoe;
        st9_next.p365y = p365_s9;
        st9_next.q100y = p100_s9[15:14];
    end

    // Stage 10: day of March-based year
    assign doy_s10 = st9_reg.doe - st9_reg.p365y - {11'd0, st9_reg.yoe[8:2]}
                     + {16'd0, st9_reg.q100y};

    always_comb begin
        st10_next.err   = st9_reg.err;
        st10_next.count = st9_reg.count;
        st10_next.era   = st9_reg.era;
        st10_next.wd    = st9_reg.wd;
        st10_next.yoe   = st9_reg.yoe;
        st10_next.doy   = doy_s10[8:0];
    end

    // Stage 11: March-based month = (5 * doy + 2) / 153
    assign x_s11  = 11'(st10_reg.doy) * 11'd5 + 11'd2;
    assign pm_s11 = 24'(x_s11) * 24'(cdcc_pkg::RCP_153);

    always_comb begin
        st11_next.err   = st10_reg.err;
        st11_next.count = st10_reg.count;
        st11_next.era   = st10_reg.era;
        st11_next.wd    = st10_reg.wd;
        st11_next.yoe   = st10_reg.yoe;
        st11_next.doy   = st10_reg.doy;
        st11_next.mp    = pm_s11[23:20];
    end

    // Output stage: day, calendar month and year; zero all fields on error
    assign day_out = st11_reg.doy - cdcc_pkg::month_start(st11_reg.mp) + 9'd1;
    assign mon_out = (st11_reg.mp < cdcc_pkg::MP_JAN) ? (st11_reg.mp + 4'd3)
                                                      : (st11_reg.mp - 4'd9);

    always_comb begin
        if (st11_reg.err) begin
            out_next.day_count   = 22'd0;
            out_next.day         = 5'd0;
            out_next.month       = 4'd0;
            out_next.year        = 14'd0;
            out_next.weekday     = 3'd0;
            out_next.range_error = 1'b1;
        end else begin
            out_next.day_count   = st11_reg.count;
            out_next.day         = day_out[4:0];
            out_next.month       = mon_out;
            out_next.year        = 14'(st11_reg.yoe)
                                   + 14'(st11_reg.era) * 14'(cdcc_pkg::ERA_YEARS)
                                   + 14'(mon_out <= cdcc_pkg::MONTH_FEB);
            out_next.weekday     = st11_reg.wd;
            out_next.range_error = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (stg_en[0])  st1_reg  <= st1_next;
        if (stg_en[1])  st2_reg  <= st2_next;
        if (stg_en[2])  st3_reg  <= st3_next;
        if (stg_en[3])  st4_reg  <= st4_next;
        if (stg_en[4])  st5_reg  <= st5_next;
        if (stg_en[5])  st6_reg  <= st6_next;
        if (stg_en[6])  st7_reg  <= st7_next;
        if (stg_en[7])  st8_reg  <= st8_next;
        if (stg_en[8])  st9_reg  <= st9_next;
        if (stg_en[9])  st10_reg <= st10_next;
        if (stg_en[10]) st11_reg <= st11_next;
        if (stg_en[11]) out_reg  <= out_next;
    end

    assign m_out_day_count = out_reg.day_count;
    assign m_out_day       = out_reg.day;
    assign m_out_month     = out_reg.month;
    assign m_out_year      = out_reg.year;
    assign m_weekday       = out_reg.weekday;
    assign m_range_error   = out_reg.range_error;

    // ---------------------------------------------------------------- assertions
    `CDCC_ASSERT_NORST(a_reset_empties, aclk, !aresetn |=> !m_valid, "beat present after reset")
    `CDCC_ASSERT(a_full_blocks_input, aclk, aresetn, (&vld_reg) && !m_ready |-> !s_ready, "input taken while pipeline full and stalled")
    `CDCC_ASSERT(a_error_zeroes, aclk, aresetn, m_valid && m_range_error |-> m_out_day_count == 22'd0 && m_out_day == 5'd0 && m_out_month == 4'd0 && m_out_year == 14'd0 && m_weekday == 3'd0, "error beat with nonzero fields")
    `CDCC_ASSERT(a_fields_sane, aclk, aresetn, m_valid && !m_range_error |-> m_weekday <= 3'd6 && m_out_month != 4'd0 && m_out_month <= 4'd12 && m_out_day != 5'd0, "date fields out of range")

endmodule
